[src/pse_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_pkg
// Types and constants shared by the postfix stack evaluator.
// ----------------------------------------------------------------------------
package pse_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int STACK_AW    = $clog2(STACK_DEPTH);
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

   localparam int TOKQ_DEPTH  = 2;
   localparam int TOKQ_AW     = $clog2(TOKQ_DEPTH);
   localparam int TOKQ_CW     = $clog2(TOKQ_DEPTH + 1);

   localparam int DATA_W      = 32;
   localparam int DIV_STEPS   = DATA_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam logic [2:0] OP_NUMBER = 3'd0;
   localparam logic [2:0] OP_ADD    = 3'd1;
   localparam logic [2:0] OP_SUB    = 3'd2;
   localparam logic [2:0] OP_MUL    = 3'd3;
   localparam logic [2:0] OP_DIV    = 3'd4;
   localparam logic [2:0] OP_MOD    = 3'd5;

   typedef struct packed {
      logic [2:0]  operation;
      logic [30:0] value;
      logic        last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result;
      logic               status;
   } rsp_type;

   typedef enum logic [2:0] {
      TK_NUM,
      TK_ADD,
      TK_SUB,
      TK_MUL,
      TK_DIV,
      TK_MOD,
      TK_BAD
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [30:0]  value;
      logic         last;
   } tok_type;

   typedef struct packed {
      logic              start;
      logic              is_mod;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] result;
   } div_rsp_type;

   typedef enum logic [1:0] {
      BS_IDLE,
      BS_OPER,
      BS_DIV,
      BS_DONE
   } bs_state_type;

endpackage

[src/pse_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/pse_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_div
// Signed 32-bit divide / remainder, restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pse_div
   import pse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    dvs_ff, dvs_in;
   logic                 qneg_ff, qneg_in;
   logic                 rneg_ff, rneg_in;
   logic                 mod_ff, mod_in;

   logic [DATA_W:0]      shifted;
   logic [DATA_W:0]      diff;
   logic [DATA_W-1:0]    a_mag;
   logic [DATA_W-1:0]    b_mag;

   always_comb begin
      a_mag   = div_req.dividend[DATA_W-1] ? (DATA_W'(0) - div_req.dividend)
                                           : div_req.dividend;
      b_mag   = div_req.divisor[DATA_W-1] ? (DATA_W'(0) - div_req.divisor)
                                          : div_req.divisor;
      shifted = {rem_ff, quo_ff[DATA_W-1]};
      diff    = shifted - {1'b0, dvs_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      qneg_in = qneg_ff;
      rneg_in = rneg_ff;
      mod_in  = mod_ff;

      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = a_mag;
         rem_in  = '0;
         dvs_in  = b_mag;
         qneg_in = div_req.dividend[DATA_W-1] ^ div_req.divisor[DATA_W-1];
         rneg_in = div_req.dividend[DATA_W-1];
         mod_in  = div_req.is_mod;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the top bit of diff is the borrow
         if (!diff[DATA_W]) begin
            rem_in = diff[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      qneg_ff <= qneg_in;
      rneg_ff <= rneg_in;
      mod_ff  <= mod_in;
   end

   always_comb begin
      div_rsp.done = done_ff;
      if (mod_ff) begin
         div_rsp.result = rneg_ff ? (DATA_W'(0) - rem_ff) : rem_ff;
      end else begin
         div_rsp.result = qneg_ff ? (DATA_W'(0) - quo_ff) : quo_ff;
      end
   end

endmodule

[src/pse_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_front
// Accepts input words, decodes the token kind and holds them in a short queue.
// ----------------------------------------------------------------------------
module pse_front
   import pse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_payload,
   output logic    tok_valid,
   output tok_type tok,
   input  logic    tok_pop
);

   tok_type              q_ff [TOKQ_DEPTH];
   logic [TOKQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [TOKQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [TOKQ_CW-1:0]   count_ff, count_in;
   logic                 push_ok;
   logic                 pop_ok;
   tok_type              tok_dec;

   always_comb begin
      case (req_payload.operation)
         OP_NUMBER: tok_dec.kind = TK_NUM;
         OP_ADD:    tok_dec.kind = TK_ADD;
         OP_SUB:    tok_dec.kind = TK_SUB;
         OP_MUL:    tok_dec.kind = TK_MUL;
         OP_DIV:    tok_dec.kind = TK_DIV;
         OP_MOD:    tok_dec.kind = TK_MOD;
         default:   tok_dec.kind = TK_BAD;
      endcase
      tok_dec.value = req_payload.value;
      tok_dec.last  = req_payload.last;
   end

   assign req_full  = (count_ff == TOKQ_CW'(TOKQ_DEPTH));
   assign tok_valid = (count_ff != '0);
   assign tok       = q_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = tok_pop && tok_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == TOKQ_AW'(TOKQ_DEPTH - 1)) ? '0
                                                             : wr_ptr_ff + TOKQ_AW'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == TOKQ_AW'(TOKQ_DEPTH - 1)) ? '0
                                                             : rd_ptr_ff + TOKQ_AW'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + TOKQ_CW'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - TOKQ_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= tok_dec;
      end
   end

endmodule

[src/pse_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_back
// Executes tokens on the operand stack and holds the finished result word.
// Top of stack lives in a register; entries below it live in the RAM.
// ----------------------------------------------------------------------------
module pse_back
   import pse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    tok_valid,
   input  tok_type tok,
   output logic    tok_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_payload
);

   bs_state_type       state_ff, state_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic               err_ff, err_in;
   logic [DATA_W-1:0]  tos_ff, tos_in;
   tok_kind_type       kind_ff, kind_in;
   logic               last_ff, last_in;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_ff, out_in;

   logic               mem_we;
   logic [STACK_AW-1:0] mem_waddr;
   logic [DATA_W-1:0]  mem_wdata;
   logic [STACK_AW-1:0] mem_raddr;
   logic [DATA_W-1:0]  mem_rdata;

   div_req_type        div_req;
   div_rsp_type        div_rsp;

   logic [DATA_W-1:0]  left;
   logic [DATA_W-1:0]  product;
   logic [DEPTH_W-1:0] depth_m1;
   logic [DEPTH_W-1:0] depth_m2;
   logic               invalid;

   pse_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   pse_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign left     = mem_rdata;
   assign product  = left * tos_ff;
   assign depth_m1 = depth_ff - DEPTH_W'(1);
   assign depth_m2 = depth_ff - DEPTH_W'(2);
   assign invalid  = err_ff || (depth_ff != DEPTH_W'(1));

   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      err_in       = err_ff;
      tos_in       = tos_ff;
      kind_in      = kind_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      tok_pop      = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = depth_m1[STACK_AW-1:0];
      mem_wdata    = tos_ff;
      mem_raddr    = depth_m2[STACK_AW-1:0];
      div_req      = '{start: 1'b0, is_mod: (kind_ff == TK_MOD),
                       dividend: left, divisor: tos_ff};

      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         BS_IDLE: begin
            if (tok_valid) begin
               tok_pop = 1'b1;
               kind_in = tok.kind;
               last_in = tok.last;
               if (tok.last) begin
                  state_in = BS_DONE;
               end
               if (!err_ff) begin
                  case (tok.kind)
                     TK_NUM: begin
                        if (depth_ff == DEPTH_W'(STACK_DEPTH)) begin
                           err_in = 1'b1;
                        end else begin
                           // spill the old top of stack to the RAM as the new one is taken
                           mem_we   = (depth_ff != '0);
                           tos_in   = {1'b0, tok.value};
                           depth_in = depth_ff + DEPTH_W'(1);
                        end
                     end
                     TK_ADD, TK_SUB, TK_MUL, TK_DIV, TK_MOD: begin
                        if (depth_ff < DEPTH_W'(2)) begin
                           err_in = 1'b1;
                        end else begin
                           state_in = BS_OPER;
                        end
                     end
                     default: err_in = 1'b1;
                  endcase
               end
            end
         end

         BS_OPER: begin
            state_in = last_ff ? BS_DONE : BS_IDLE;
            case (kind_ff)
               TK_ADD: begin
                  tos_in   = left + tos_ff;
                  depth_in = depth_m1;
               end
               TK_SUB: begin
                  tos_in   = left - tos_ff;
                  depth_in = depth_m1;
               end
               TK_MUL: begin
                  tos_in   = product;
                  depth_in = depth_m1;
               end
               default: begin
                  if (tos_ff == '0) begin
                     err_in = 1'b1;
                  end else begin
                     div_req.start = 1'b1;
                     state_in      = BS_DIV;
                  end
               end
            endcase
         end

         BS_DIV: begin
            if (div_rsp.done) begin
               tos_in   = div_rsp.result;
               depth_in = depth_m1;
               state_in = last_ff ? BS_DONE : BS_IDLE;
            end
         end

         BS_DONE: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in  = 1'b1;
               out_in.result = invalid ? '0 : tos_ff;
               out_in.status = invalid;
               depth_in      = '0;
               err_in        = 1'b0;
               state_in      = BS_IDLE;
            end
         end

         default: state_in = BS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         depth_ff     <= '0;
         err_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         err_ff       <= err_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff  <= tos_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
      out_ff  <= out_in;
   end

   assign rsp_empty   = !out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

[src/postfix_stack_evaluator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Evaluates postfix integer expressions one token word at a time.
//
//   channel   handshake          payload      direction
//   req_      push / full        req_type     token words in
//   rsp_      empty / pop        rsp_type     one result word per last token
//
// A number token is pushed directly; + - * read the stack RAM, then apply the
// ALU; / and % go through the bit-serial divider (32 steps plus start and
// writeback). A last token then loads the result register once it is free.
// Reset is synchronous and empties the token queue, the stack and the result
// register; the stack RAM needs no clearing pass. The token queue keeps
// accepting while a result waits to be popped.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator
   import pse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_payload,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_payload
);

   logic    tok_valid;
   tok_type tok;
   logic    tok_pop;

   pse_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .tok_valid   (tok_valid),
      .tok         (tok),
      .tok_pop     (tok_pop)
   );

   pse_back u_back (
      .clock       (clock),
      .reset       (reset),
      .tok_valid   (tok_valid),
      .tok         (tok),
      .tok_pop     (tok_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload)
   );

endmodule

[src/pse_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_checker
// Port-level checks for the postfix stack evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module pse_checker
   import pse_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_payload
);

   // reset drops any pending result word
   a_reset_empty : assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending after reset");

   // reset drains the token queue
   a_reset_room : assert property (@(posedge clock) reset |=> !req_full)
      else $error("token queue full after reset");

   // an invalid expression reports zero
   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_payload.status) |-> (rsp_payload.result == 32'sd0))
      else $error("invalid result is not zero");

   // a waiting result word holds until popped
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_payload)))
      else $error("result word changed before pop");

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (.*);

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for postfix_stack_evaluator. A directed table of token
// words comes first. Random expressions follow: well-formed ones, truncated
// ones, noise, full-depth and overflow stacks, and the most negative value
// divided by -1. Result words are checked against a bench evaluator or a
// directed row's word. The sender works in bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
   import pse_pkg::*;

   localparam logic [2:0] OP_OTHER    = 3'd6;
   localparam logic [2:0] OP_UNUSED   = 3'd7;
   localparam logic       ST_VALID    = 1'b0;
   localparam logic       ST_INVALID  = 1'b1;
   localparam logic [30:0] MAX31      = 31'h7FFF_FFFF;
   localparam int         RANDOM_WORDS = 500;
   localparam int         LONG_HOLD   = 400;
   localparam int         DRAIN_CYCLES = 100;
   localparam int         CYCLE_LIMIT = 400000;

   typedef enum logic [1:0] {
      POP_ALWAYS,
      POP_HALF,
      POP_RARE,
      POP_BEAT
   } pop_mode_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [30:0] value;
      logic        last;
      logic        fixed_exp;
      logic [31:0] result;
      logic        status;
   } row_type;

   // directed words; fixed_exp rows carry their own expected result word
   row_type dir_rows [26] = '{
      '{OP_NUMBER, MAX31, 1'b1, 1'b1, 32'h7FFF_FFFF, ST_VALID},
      '{OP_NUMBER, MAX31, 1'b0, 1'b0, 32'h0, ST_VALID},
      '{OP_NUMBER, 31'd1, 1'b0, 1'b0, 32'h0, ST_VALID},
      '{OP_ADD,    31'd0, 1'b1, 1'b1, 32'h8000_0000, ST_VALID},
      '{OP_NUMBER, 31'd0, 1'b0, 1'b0, 32'h0, ST_VALID},
      '{OP_NUMBER, 31'd1, 1'b0, 1'b0, 32'h0, ST_VALID},
      '{OP_SUB,    MAX31, 1'b1, 1'b1, 32'hFFFF_FFFF, ST_VALID},
      '{OP_NUMBER, MAX31, 1'b0, 1'b0, 32'h0, ST_VALID},
      '{OP_NUMBER, MAX31, 1'b0, 1'b0, 32'h0, ST_VALID},
      '{OP_MUL,    31'd0, 1'b1, 1'b0, 32'h0, ST_VALID},
      '{OP_NUMBER, 31'd0, 1'b0, 1'b0, 32'h0, ST_VALID},
      '{OP_NUMBER, 31'd7, 1'b0, 1'b0, 32'h0, ST_VALID},
      '{OP_SUB,    31'd0, 1'b0, 1'b0, 32'h0, ST_VALID},
      '{OP_NUMBER, 31'd2, 1'b0, 1'b0, 32'h0, ST_VALID},
      '{OP_DIV,    31'd0, 1'b1, 1'b0, 32'h0, ST_VALID},
      '{OP_NUMBER, 31'd7, 1'b0, 1'b0, 32'h0, ST_VALID},
      '{OP_NUMBER, 31'd0, 1'b0, 1'b0, 32'h0, ST_VALID},
      '{OP_DIV,    31'd0, 1'b1, 1'b1, 32'h0, ST_INVALID},
      '{OP_NUMBER, MAX31, 1'b0, 1'b0, 32'h0, ST_VALID},
      '{OP_NUMBER, 31'd0, 1'b0, 1'b0, 32'h0, ST_VALID},
      '{OP_MOD,    31'd0, 1'b1, 1'b1, 32'h0, ST_INVALID},
      '{OP_ADD,    31'd0, 1'b1, 1'b1, 32'h0, ST_INVALID},
      '{OP_OTHER,  31'd5, 1'b1, 1'b1, 32'h0, ST_INVALID},
      '{OP_UNUSED, MAX31, 1'b1, 1'b1, 32'h0, ST_INVALID},
      '{OP_NUMBER, 31'd1, 1'b0, 1'b0, 32'h0, ST_VALID},
      '{OP_NUMBER, 31'd2, 1'b1, 1'b1, 32'h0, ST_INVALID}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_payload = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_payload;

   // evaluator state
   logic [31:0] opnd_stack [STACK_DEPTH];
   int          opnd_depth = 0;
   bit          expr_error = 1'b0;

   rsp_type pending_results [$];
   req_type expr_words [$];

   int err_count = 0;
   int words_sent = 0;
   int exprs_sent = 0;
   int results_seen = 0;
   int invalid_seen = 0;
   int full_stalls = 0;
   int burst_left = 0;
   bit gaps_on = 1'b1;
   bit hold_req = 1'b0;
   int cycle_count = 0;

   postfix_stack_evaluator uut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload)
   );

   always #2 clock = ~clock;

   function automatic req_type mk_word(logic [2:0] op, logic [30:0] val, logic l);
      return {op, val, l};
   endfunction

   // applies one token word; returns 1 with the result word on a last token
   function automatic bit eval_token(input req_type w, output rsp_type r);
      logic [31:0] lhs, rhs, lmag, rmag, quo, res;
      bit          inv;
      r = '0;
      res = '0;
      if (!expr_error) begin
         if (w.operation == OP_NUMBER) begin
            if (opnd_depth >= STACK_DEPTH) begin
               expr_error = 1'b1;
            end else begin
               opnd_stack[opnd_depth] = {1'b0, w.value};
               opnd_depth++;
            end
         end else if (w.operation > OP_MOD || opnd_depth < 2) begin
            expr_error = 1'b1;
         end else begin
            rhs = opnd_stack[opnd_depth - 1];
            lhs = opnd_stack[opnd_depth - 2];
            lmag = lhs[31] ? 32'd0 - lhs : lhs;
            rmag = rhs[31] ? 32'd0 - rhs : rhs;
            if ((w.operation == OP_DIV || w.operation == OP_MOD) && rhs == 32'd0) begin
               expr_error = 1'b1;
            end else begin
               case (w.operation)
                  OP_ADD: res = lhs + rhs;
                  OP_SUB: res = lhs - rhs;
                  OP_MUL: res = lhs * rhs;
                  OP_DIV: begin
                     quo = lmag / rmag;
                     res = (lhs[31] ^ rhs[31]) ? 32'd0 - quo : quo;
                  end
                  default: begin
                     quo = lmag % rmag;
                     res = lhs[31] ? 32'd0 - quo : quo;
                  end
               endcase
               opnd_depth--;
               opnd_stack[opnd_depth - 1] = res;
            end
         end
      end
      if (!w.last)
         return 1'b0;
      inv = expr_error || opnd_depth != 1;
      r.result = inv ? 32'd0 : opnd_stack[0];
      r.status = inv ? ST_INVALID : ST_VALID;
      opnd_depth = 0;
      expr_error = 1'b0;
      return 1'b1;
   endfunction

   // offers one word, waits for it to be taken, then records what it yields
   task automatic send_word(input req_type w, input bit fixed_exp, input rsp_type fixed_rsp);
      rsp_type pred;
      int      gap;
      if (gaps_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
               req_push <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
      end
      req_push <= 1'b1;
      req_payload <= w;
      do begin
         @(posedge clock);
         if (req_full)
            full_stalls++;
      end while (req_full);
      words_sent++;
      if (eval_token(w, pred)) begin
         pending_results.push_back(fixed_exp ? fixed_rsp : pred);
         exprs_sent++;
      end
   endtask

   function automatic logic [30:0] rand_operand();
      case ($urandom_range(0, 9))
         0: return 31'd0;
         1: return 31'd1;
         2: return MAX31;
         3, 4: return 31'($urandom_range(2, 20));
         default: return 31'($urandom);
      endcase
   endfunction

   function automatic logic [2:0] rand_arith();
      return OP_ADD + 3'($urandom_range(0, 4));
   endfunction

   task automatic add_word(logic [2:0] op, logic [30:0] val);
      expr_words.push_back(mk_word(op, val, 1'b0));
   endtask

   // well-formed expression over n_leaves numbers
   task automatic gen_wellformed(int n_leaves, bit pushes_first);
      int depth, pushes, ops;
      depth = 0;
      pushes = n_leaves;
      ops = n_leaves - 1;
      while (pushes + ops > 0) begin
         if (pushes > 0 && (depth < 2 || pushes_first || $urandom_range(0, 1))) begin
            add_word(OP_NUMBER, rand_operand());
            depth++;
            pushes--;
         end else begin
            add_word(rand_arith(), 31'($urandom));
            depth--;
            ops--;
         end
      end
   endtask

   task automatic send_expr();
      req_type w;
      foreach (expr_words[i]) begin
         w = expr_words[i];
         w.last = (i == expr_words.size() - 1);
         send_word(w, 1'b0, '0);
      end
   endtask

   // receiver: checks result words and stalls on its own pattern
   int rx_cycle = 0;
   int hold_left = 0;
   bit hold_taken = 1'b0;
   rsp_type want;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            results_seen++;
            if (rsp_payload.status == ST_INVALID)
               invalid_seen++;
            if (pending_results.size() == 0) begin
               $display("%0t: result word with nothing expected, got %0d status %0d",
                        $time, rsp_payload.result, rsp_payload.status);
               err_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_payload.result !== want.result) begin
                  $display("%0t: result mismatch, expected %0d, got %0d",
                           $time, want.result, rsp_payload.result);
                  err_count++;
               end
               if (rsp_payload.status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $time, want.status, rsp_payload.status);
                  err_count++;
               end
            end
         end
         rx_cycle++;
         if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            case (pop_mode_type'(rx_cycle[9:8]))
               POP_ALWAYS: rsp_pop <= 1'b1;
               POP_HALF:   rsp_pop <= 1'($urandom_range(0, 1));
               POP_RARE:   rsp_pop <= ($urandom_range(0, 5) == 0);
               default:    rsp_pop <= (rx_cycle % 7 < 3);
            endcase
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int pick;
      int expr_idx;
      int total_words;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i])
         send_word(mk_word(dir_rows[i].op, dir_rows[i].value, dir_rows[i].last),
                   dir_rows[i].fixed_exp, {dir_rows[i].result, dir_rows[i].status});

      // back-to-back words against a receiver that holds off for a long time
      gaps_on = 1'b0;
      hold_req = 1'b1;
      repeat (30) begin
         expr_words.delete();
         gen_wellformed($urandom_range(1, 3), 1'b0);
         send_expr();
      end
      gaps_on = 1'b1;

      total_words = words_sent + RANDOM_WORDS;
      expr_idx = 0;
      while (words_sent < total_words) begin
         expr_words.delete();
         if (expr_idx == 8) begin
            gen_wellformed(STACK_DEPTH, 1'b1);
         end else if (expr_idx == 20) begin
            gen_wellformed(STACK_DEPTH + 1, 1'b1);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               gen_wellformed($urandom_range(1, 6), 1'b0);
            end else if (pick < 72) begin
               gen_wellformed($urandom_range(7, 20), 1'b0);
            end else if (pick < 82) begin
               // truncated expression: ends with depth off or mid-operator
               gen_wellformed($urandom_range(2, 6), 1'b0);
               repeat ($urandom_range(1, expr_words.size() - 1))
                  void'(expr_words.pop_back());
            end else if (pick < 92) begin
               repeat ($urandom_range(1, 5))
                  add_word(3'($urandom_range(0, 7)), 31'($urandom));
            end else begin
               // most negative value against -1
               add_word(OP_NUMBER, MAX31);
               add_word(OP_NUMBER, 31'd1);
               add_word(OP_ADD, 31'($urandom));
               add_word(OP_NUMBER, 31'd0);
               add_word(OP_NUMBER, 31'd1);
               add_word(OP_SUB, 31'($urandom));
               add_word($urandom_range(0, 1) ? OP_DIV : OP_MOD, 31'($urandom));
            end
         end
         if (expr_idx == 40) begin
            req_push <= 1'b0;
            while (pending_results.size() != 0)
               @(posedge clock);
         end
         send_expr();
         expr_idx++;
      end
      req_push <= 1'b0;

      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d token words in %0d expressions; %0d results checked, %0d invalid.",
               words_sent, exprs_sent, results_seen, invalid_seen);
      $display("Input saw full for %0d cycles, including one %0d-cycle result hold-off.",
               full_stalls, LONG_HOLD);
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[files.f]
src/pse_pkg.sv
src/pse_ram.sv
src/pse_div.sv
src/pse_front.sv
src/pse_back.sv
src/postfix_stack_evaluator.sv
src/pse_checker.sv
test/testbench.sv
